FILE: hw/rtl/gps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gps_pkg;

    // Field widths
    localparam int TICK_W      = 31;
    localparam int DUR_W       = 12;
    localparam int PATTERN_W   = 16;
    localparam int LEGS        = 4;
    localparam int PHASE_OUT_W = 2;
    localparam int INTO_W      = 12;

    // Phases covered by the contact pattern register
    localparam int PATTERN_PHASES = PATTERN_W / LEGS;

    // Phase count limits and default
    localparam int NUM_PHASES_DEFAULT = 4;
    localparam int PHASE_IDX_W        = 3;

    // Configuration port
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CONTACT = 2'd0,
        REG_STANCE  = 2'd1,
        REG_SWING   = 2'd2
    } cfg_reg_t;

    // Contact legs of one phase; phases past the pattern have no contact
    function automatic logic [LEGS-1:0] legs_of(
        input logic [PATTERN_W-1:0]   pattern,
        input logic [PHASE_IDX_W-1:0] idx
    );
        logic [LEGS-1:0] legs;
        legs = '0;
        if (idx < PHASE_IDX_W'(PATTERN_PHASES))
        begin
            legs = pattern[{idx[1:0], 2'b00} +: LEGS];
        end
        return legs;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gps_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Tick input channel
interface gps_tick_if;
    logic                      valid;
    logic                      ready;
    logic [gps_pkg::TICK_W-1:0] tick_count;

    modport source (output valid, output tick_count, input ready);
    modport sink   (input valid, input tick_count, output ready);
endinterface

// Result output channel
interface gps_result_if;
    logic                           valid;
    logic                           ready;
    logic [gps_pkg::PHASE_OUT_W-1:0] phase_number;
    logic [gps_pkg::INTO_W-1:0]      ticks_into_phase;
    logic [gps_pkg::LEGS-1:0]        contact_mask;

    modport source (output valid, output phase_number, output ticks_into_phase,
                    output contact_mask, input ready);
    modport sink   (input valid, input phase_number, input ticks_into_phase,
                    input contact_mask, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gps_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module gps_cfg #(
    parameter int NUM_PHASES = gps_pkg::NUM_PHASES_DEFAULT,
    parameter int CYC_W      = gps_pkg::DUR_W + 2
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [gps_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  wire logic [gps_pkg::CFG_DATA_W-1:0]     wr_data,
    output logic [gps_pkg::PATTERN_W-1:0]           pattern,
    output logic [gps_pkg::DUR_W-1:0]               stance,
    output logic [gps_pkg::DUR_W-1:0]               swing,
    output logic [NUM_PHASES-1:0][CYC_W-1:0]        starts,
    output logic [NUM_PHASES-1:0][CYC_W-1:0]        ends,
    output logic [CYC_W-1:0]                        cycle_len,
    output logic                                    cycle_zero,
    output logic                                    settle
);

    logic [gps_pkg::PATTERN_W-1:0]    pattern_reg;
    logic [gps_pkg::DUR_W-1:0]        stance_reg;
    logic [gps_pkg::DUR_W-1:0]        swing_reg;
    logic [NUM_PHASES-1:0][CYC_W-1:0] starts_reg, starts_next;
    logic [NUM_PHASES-1:0][CYC_W-1:0] ends_reg, ends_next;
    logic                             settle_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            stance_reg  <= gps_pkg::DUR_W'(1);
            swing_reg   <= gps_pkg::DUR_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                gps_pkg::REG_CONTACT: pattern_reg <= wr_data;
                gps_pkg::REG_STANCE:  stance_reg  <= wr_data[gps_pkg::DUR_W-1:0];
                gps_pkg::REG_SWING:   swing_reg   <= wr_data[gps_pkg::DUR_W-1:0];
                default: ;
            endcase
        end
    end

    // Phase boundaries: running sum of phase durations
    always_comb
    begin
        logic [CYC_W-1:0] acc;
        logic [CYC_W-1:0] dur;
        acc = '0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (gps_pkg::legs_of(pattern_reg, gps_pkg::PHASE_IDX_W'(p)) == '1)
                dur = CYC_W'(stance_reg);
            else
                dur = CYC_W'(swing_reg);
            starts_next[p] = acc;
            acc            = acc + dur;
            ends_next[p]   = acc;
        end
    end

    // Boundaries are registered from the settings registers; input is held off while they catch up
    always_ff @(posedge clk)
    begin
        starts_reg <= starts_next;
        ends_reg   <= ends_next;
    end

    // Hold input off while the boundaries catch up with reset or a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= 1'b1;
        else
            settle_reg <= wr_en;
    end

    assign pattern    = pattern_reg;
    assign stance     = stance_reg;
    assign swing      = swing_reg;
    assign starts     = starts_reg;
    assign ends       = ends_reg;
    assign cycle_len  = ends_reg[NUM_PHASES-1];
    assign cycle_zero = (ends_reg[NUM_PHASES-1] == '0);
    assign settle     = settle_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/gps_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One restoring remainder step: brings in one tick bit per cell
module gps_cell #(
    parameter int CYC_W = gps_pkg::DUR_W + 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [CYC_W-1:0]           cycle_len,
    input  wire logic                       up_valid,
    output logic                            up_ready,
    input  wire logic [CYC_W-1:0]           rem_up,
    input  wire logic [gps_pkg::TICK_W-1:0] dvd_up,
    output logic                            dn_valid,
    input  wire logic                       dn_ready,
    output logic [CYC_W-1:0]                rem_dn,
    output logic [gps_pkg::TICK_W-1:0]      dvd_dn
);

    logic                       valid_reg;
    logic [CYC_W-1:0]           rem_reg, rem_next;
    logic [gps_pkg::TICK_W-1:0] dvd_reg, dvd_next;
    logic [CYC_W:0]             trial;

    // Shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        trial = {rem_up, dvd_up[gps_pkg::TICK_W-1]};
        if (trial >= {1'b0, cycle_len})
            rem_next = CYC_W'(trial - {1'b0, cycle_len});
        else
            rem_next = CYC_W'(trial);
        dvd_next = {dvd_up[gps_pkg::TICK_W-2:0], 1'b0};
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign dn_valid = valid_reg;
    assign rem_dn   = rem_reg;
    assign dvd_dn   = dvd_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/gps_locate.sv
`timescale 1ns / 1ps
`default_nettype none

// Phase search on the reduced tick and the output register
module gps_locate #(
    parameter int NUM_PHASES = gps_pkg::NUM_PHASES_DEFAULT,
    parameter int CYC_W      = gps_pkg::DUR_W + 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire logic [CYC_W-1:0]              pos,
    input  wire logic                          cycle_zero,
    input  wire logic [NUM_PHASES-1:0][CYC_W-1:0] starts,
    input  wire logic [NUM_PHASES-1:0][CYC_W-1:0] ends,
    input  wire logic [gps_pkg::PATTERN_W-1:0] pattern,
    gps_result_if.source                       results
);

    localparam int PH_W = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;

    logic [PH_W-1:0]                 sel;
    logic [gps_pkg::INTO_W-1:0]      into_next;
    logic                            valid_reg;
    logic [gps_pkg::PHASE_OUT_W-1:0] phase_reg;
    logic [gps_pkg::INTO_W-1:0]      into_reg;
    logic [gps_pkg::LEGS-1:0]        mask_reg;

    // First phase whose end lies past the position
    always_comb
    begin
        sel = '0;
        for (int p = NUM_PHASES - 1; p >= 0; p--)
        begin
            if (pos < ends[p])
                sel = PH_W'(p);
        end
        if (cycle_zero)
            sel = '0;
        into_next = cycle_zero ? '0 : gps_pkg::INTO_W'(pos - starts[sel]);
    end

    assign up_ready = !valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            phase_reg <= gps_pkg::PHASE_OUT_W'(sel);
            into_reg  <= into_next;
            mask_reg  <= gps_pkg::legs_of(pattern, gps_pkg::PHASE_IDX_W'(sel));
        end
    end

    assign results.valid            = valid_reg;
    assign results.phase_number     = phase_reg;
    assign results.ticks_into_phase = into_reg;
    assign results.contact_mask     = mask_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/gait_phase_scheduler.sv
// Pipeline: 31 remainder cells, one per tick bit, the first loaded as a tick is
//   accepted, followed by the phase search register.
// Throughput: one tick per cycle unless output stalls; every stage has its own valid
//   bit, so bubbles are squeezed out in a stall. Input is held off after each write.
// Reset: asynchronous, active low; clears all valid bits, restores an empty contact
//   pattern with unit stance and swing, and holds input off while boundaries settle.
`timescale 1ns / 1ps
`default_nettype none

module gait_phase_scheduler #(
    parameter int NUM_PHASES = gps_pkg::NUM_PHASES_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    gps_tick_if.sink                             ticks,
    gps_result_if.source                         results,
    input  wire logic                            wr_en,
    input  wire logic [gps_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [gps_pkg::CFG_DATA_W-1:0]  wr_data
);

    localparam int CYC_W = gps_pkg::DUR_W + ((NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 0);
    localparam int NCELL = gps_pkg::TICK_W;

    logic [gps_pkg::PATTERN_W-1:0]    pattern;
    logic [gps_pkg::DUR_W-1:0]        stance;
    logic [gps_pkg::DUR_W-1:0]        swing;
    logic [NUM_PHASES-1:0][CYC_W-1:0] starts;
    logic [NUM_PHASES-1:0][CYC_W-1:0] ends;
    logic [CYC_W-1:0]                 cycle_len;
    logic                             cycle_zero;
    logic                             settle;

    logic                       valid_c [0:NCELL];
    logic                       ready_c [0:NCELL];
    logic [CYC_W-1:0]           rem_c   [0:NCELL];
    logic [gps_pkg::TICK_W-1:0] dvd_c   [0:NCELL];

    gps_cfg #(
        .NUM_PHASES (NUM_PHASES),
        .CYC_W      (CYC_W)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .pattern    (pattern),
        .stance     (stance),
        .swing      (swing),
        .starts     (starts),
        .ends       (ends),
        .cycle_len  (cycle_len),
        .cycle_zero (cycle_zero),
        .settle     (settle)
    );

    // Head of the remainder chain; closed while the boundaries settle
    assign valid_c[0]  = ticks.valid && !settle;
    assign ticks.ready = ready_c[0] && !settle;
    assign rem_c[0]    = '0;
    assign dvd_c[0]    = ticks.tick_count;

    // Chain of remainder cells
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        gps_cell #(
            .CYC_W (CYC_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cycle_len (cycle_len),
            .up_valid  (valid_c[i]),
            .up_ready  (ready_c[i]),
            .rem_up    (rem_c[i]),
            .dvd_up    (dvd_c[i]),
            .dn_valid  (valid_c[i+1]),
            .dn_ready  (ready_c[i+1]),
            .rem_dn    (rem_c[i+1]),
            .dvd_dn    (dvd_c[i+1])
        );
    end

    gps_locate #(
        .NUM_PHASES (NUM_PHASES),
        .CYC_W      (CYC_W)
    ) u_locate (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (valid_c[NCELL]),
        .up_ready   (ready_c[NCELL]),
        .pos        (rem_c[NCELL]),
        .cycle_zero (cycle_zero),
        .starts     (starts),
        .ends       (ends),
        .pattern    (pattern),
        .results    (results)
    );

    // Input backs up only while settling or when every stage is full and the output stalls
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !ticks.ready |-> (settle || (results.valid && !results.ready)))
        else $error("input stalled while the pipeline has room");

    // An empty cycle reports phase zero at its start
    a_empty_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && cycle_zero) |->
            (results.phase_number == '0 && results.ticks_into_phase == '0))
        else $error("empty cycle gave a nonzero phase or offset");

    // Offset within a phase stays below the longer phase duration
    a_into_range: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !cycle_zero) |->
            (results.ticks_into_phase < stance || results.ticks_into_phase < swing))
        else $error("ticks into phase exceed both durations");

    // Chained remainder stays below the cycle length
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_c[NCELL] && !cycle_zero) |-> (rem_c[NCELL] < cycle_len))
        else $error("remainder not reduced below the cycle length");

endmodule

`default_nettype wire

FILE: sim/gait_phase_scheduler_tb.sv
`timescale 1ns / 1ps

module gait_phase_scheduler_tb;

    localparam int TICK_W      = gps_pkg::TICK_W;
    localparam int PHASE_OUT_W = gps_pkg::PHASE_OUT_W;
    localparam int INTO_W      = gps_pkg::INTO_W;
    localparam int LEGS        = gps_pkg::LEGS;
    localparam int PATTERN_W   = gps_pkg::PATTERN_W;
    localparam int DUR_W       = gps_pkg::DUR_W;
    localparam int CFG_DATA_W  = gps_pkg::CFG_DATA_W;

    localparam int PHASES        = gps_pkg::NUM_PHASES_DEFAULT;
    localparam int SEGMENTS      = 14;
    localparam int SEGMENT_ITEMS = 125;
    localparam int LATENCY       = 32;
    localparam int CYCLE_LIMIT   = 200000;

    // One expected result, tagged with the tick that caused it
    typedef struct packed {
        logic [TICK_W-1:0]      tick;
        logic [PHASE_OUT_W-1:0] phase;
        logic [INTO_W-1:0]      into;
        logic [LEGS-1:0]        mask;
    } phase_hit_t;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_SPARSE,
        STALL_LONG
    } stall_mode_t;

    typedef enum int {
        DUR_ZERO_STANCE,
        DUR_ZERO_SWING,
        DUR_EMPTY_CYCLE,
        DUR_RAW_DATA,
        DUR_SHORT,
        DUR_SHORT_ALT,
        DUR_SHORT_MORE,
        DUR_FULL_RANGE
    } dur_kind_t;

    // Gait scoreboard: mirrors the registers and queues expected phase hits
    class gait_scoreboard;
        logic [PATTERN_W-1:0] pattern;
        logic [DUR_W-1:0]     stance;
        logic [DUR_W-1:0]     swing;
        phase_hit_t           pending_hits[$];
        int                   errors;

        function new();
            pattern = '0;
            stance  = DUR_W'(1);
            swing   = DUR_W'(1);
            errors  = 0;
        endfunction

        function void set_register(gps_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                gps_pkg::REG_CONTACT: pattern = data[PATTERN_W-1:0];
                gps_pkg::REG_STANCE:  stance  = data[DUR_W-1:0];
                gps_pkg::REG_SWING:   swing   = data[DUR_W-1:0];
                default: ;
            endcase
        endfunction

        // Phases past the 16-bit pattern have no legs down
        function logic [LEGS-1:0] phase_legs(int p);
            if (p >= PATTERN_W / LEGS)
                return '0;
            return pattern[p*LEGS +: LEGS];
        endfunction

        function int unsigned phase_span(int p);
            return (phase_legs(p) == '1) ? int'(stance) : int'(swing);
        endfunction

        function int unsigned cycle_length();
            int unsigned total;
            total = 0;
            for (int p = 0; p < PHASES; p++)
                total += phase_span(p);
            return total;
        endfunction

        function phase_hit_t locate(logic [TICK_W-1:0] tick);
            phase_hit_t  hit;
            int unsigned cycle;
            int unsigned pos;
            int unsigned start;
            int          found;
            cycle = cycle_length();
            start = 0;
            found = 0;
            hit.tick = tick;
            hit.into = '0;
            // empty cycle falls through to phase 0 with no elapsed ticks
            if (cycle != 0)
            begin
                pos = int'(tick) % cycle;
                for (int p = 0; p < PHASES; p++)
                begin
                    if (pos < start + phase_span(p))
                    begin
                        found    = p;
                        hit.into = INTO_W'(pos - start);
                        break;
                    end
                    start += phase_span(p);
                end
            end
            hit.phase = PHASE_OUT_W'(found);
            hit.mask  = phase_legs(found);
            return hit;
        endfunction

        function void note_tick(logic [TICK_W-1:0] tick);
            pending_hits.insert(pending_hits.size(), locate(tick));
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [PHASE_OUT_W-1:0] phase, logic [INTO_W-1:0] into,
                          logic [LEGS-1:0] mask);
            phase_hit_t want;
            if (pending_hits.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result phase %0d into %0d mask %h",
                                          phase, into, mask));
                return;
            end
            want = pending_hits.pop_front();
            if (phase !== want.phase)
                report_mismatch($sformatf("tick %0d: phase_number %0d, expected %0d",
                                          want.tick, phase, want.phase));
            if (into !== want.into)
                report_mismatch($sformatf("tick %0d: ticks_into_phase %0d, expected %0d",
                                          want.tick, into, want.into));
            if (mask !== want.mask)
                report_mismatch($sformatf("tick %0d: contact_mask %h, expected %h",
                                          want.tick, mask, want.mask));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   wr_en;
    gps_pkg::cfg_reg_t      wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;
    stall_mode_t            stall_mode;
    logic [4:0]             stall_phase;
    int                     cycle_count;
    gait_scoreboard         sb;

    gps_tick_if   tick_ch();
    gps_result_if result_ch();

    gait_phase_scheduler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .ticks    (tick_ch),
        .results  (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_phase     <= '0;
        end
        else
        begin
            stall_phase <= stall_phase + 5'd1;
            case (stall_mode)
                STALL_NONE:   result_ch.ready <= 1'b1;
                STALL_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                STALL_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
                default:      result_ch.ready <= (stall_phase >= 5'd20);
            endcase
        end
    end

    // Transaction monitor: note accepted ticks, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_ch.valid && tick_ch.ready)
                sb.note_tick(tick_ch.tick_count);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.phase_number, result_ch.ticks_into_phase,
                                result_ch.contact_mask);
        end
    end

    // Present one tick and hold it until the block takes it
    task send_tick(logic [TICK_W-1:0] tick);
        tick_ch.valid      <= 1'b1;
        tick_ch.tick_count <= tick;
        do
            @(posedge clk);
        while (!tick_ch.ready);
    endtask

    task idle_sender(int cycles);
        tick_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop sending and wait for every expected result to come back
    task drain();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_hits.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Write all three registers while the block is idle
    task configure(logic [CFG_DATA_W-1:0] pattern, logic [CFG_DATA_W-1:0] stance,
                   logic [CFG_DATA_W-1:0] swing);
        drain();
        wr_en    <= 1'b1;
        wr_index <= gps_pkg::REG_CONTACT;
        wr_data  <= pattern;
        sb.set_register(gps_pkg::REG_CONTACT, pattern);
        @(posedge clk);
        wr_index <= gps_pkg::REG_STANCE;
        wr_data  <= stance;
        sb.set_register(gps_pkg::REG_STANCE, stance);
        @(posedge clk);
        wr_index <= gps_pkg::REG_SWING;
        wr_data  <= swing;
        sb.set_register(gps_pkg::REG_SWING, swing);
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] pattern;
        logic [CFG_DATA_W-1:0] stance;
        logic [CFG_DATA_W-1:0] swing;
        logic [TICK_W-1:0]     tick;
        dur_kind_t             kind;
        int unsigned           cycle;
        int                    burst_left;

        rst_n                = 1'b0;
        wr_en                = 1'b0;
        wr_index             = gps_pkg::REG_CONTACT;
        wr_data              = '0;
        tick_ch.valid        = 1'b0;
        tick_ch.tick_count   = '0;
        result_ch.ready      = 1'b0;
        stall_mode           = STALL_NONE;
        cycle_count          = 0;
        sb                   = new();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: four unit swing phases
        send_tick('0);
        send_tick(TICK_W'(1));
        send_tick(TICK_W'(5));
        send_tick('1);

        // Longest cycle, all stance
        configure(16'hFFFF, 16'd4095, 16'd4095);
        send_tick('1);
        send_tick(TICK_W'(16379));
        send_tick(TICK_W'(16380));
        send_tick(TICK_W'(4095));

        // Mixed stance and swing: boundaries at 3, 8, 11, 16
        configure(16'h0F3F, 16'd3, 16'd5);
        send_tick(TICK_W'(2));
        send_tick(TICK_W'(3));
        send_tick(TICK_W'(7));
        send_tick(TICK_W'(8));
        send_tick(TICK_W'(11));
        send_tick(TICK_W'(15));
        send_tick(TICK_W'(16));

        // Zero-length stance phases are skipped (upper data bits dropped)
        configure(16'hF00F, 16'hF000, 16'd4);
        send_tick(TICK_W'(0));
        send_tick(TICK_W'(3));
        send_tick(TICK_W'(4));
        send_tick(TICK_W'(7));

        // Empty cycle reports phase 0
        configure(16'hA5C3, 16'd0, 16'd0);
        send_tick(TICK_W'(0));
        send_tick(TICK_W'(12345));

        // Random segments, each with its own settings and receiver behavior
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            pattern = 16'($urandom);
            for (int p = 0; p < PATTERN_W / LEGS; p++)
                if ($urandom_range(0, 1) == 1)
                    pattern[p*LEGS +: LEGS] = '1;
            kind = dur_kind_t'($urandom_range(0, 7));
            case (kind)
                DUR_ZERO_STANCE:
                begin
                    stance = {4'($urandom), 12'h000};
                    swing  = 16'($urandom_range(1, 4095));
                end
                DUR_ZERO_SWING:
                begin
                    stance = 16'($urandom_range(1, 4095));
                    swing  = {4'($urandom), 12'h000};
                end
                DUR_EMPTY_CYCLE:
                begin
                    stance = '0;
                    swing  = '0;
                end
                DUR_RAW_DATA:
                begin
                    stance = 16'($urandom);
                    swing  = 16'($urandom);
                end
                DUR_SHORT, DUR_SHORT_ALT, DUR_SHORT_MORE:
                begin
                    stance = 16'($urandom_range(1, 8));
                    swing  = 16'($urandom_range(1, 8));
                end
                default:
                begin
                    stance = 16'($urandom_range(1, 4095));
                    swing  = 16'($urandom_range(1, 4095));
                end
            endcase
            configure(pattern, stance, swing);
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            cycle      = sb.cycle_length();
            burst_left = 0;

            for (int i = 0; i < SEGMENT_ITEMS; i++)
            begin
                // once, hold off the sender until the pipeline is empty
                if (seg == 5 && i == SEGMENT_ITEMS / 2)
                    drain();
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                        burst_left = SEGMENT_ITEMS;
                    else
                    begin
                        idle_sender($urandom_range(1, 8));
                        burst_left = $urandom_range(1, 40);
                    end
                end
                // half near the cycle to hit boundaries, half anywhere
                if (cycle != 0 && $urandom_range(0, 1) == 1)
                    tick = TICK_W'($urandom_range(0, 3 * cycle + 2));
                else
                    tick = TICK_W'($urandom);
                send_tick(tick);
                burst_left--;
            end
        end

        // Let everything come out, then watch for stray results
        drain();
        stall_mode <= STALL_NONE;
        repeat (LATENCY + 8) @(posedge clk);
        if (sb.pending_hits.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_hits.size()));

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/gps_pkg.sv
hw/rtl/gps_if.sv
hw/rtl/gps_cfg.sv
hw/rtl/gps_cell.sv
hw/rtl/gps_locate.sv
hw/rtl/gait_phase_scheduler.sv
sim/gait_phase_scheduler_tb.sv
